>>> rtl/lkvc_pkg.sv
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int DATA_W  = 32;
  localparam int EFF_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [CAP_W-1:0]         cap_t;
  typedef logic [EFF_W-1:0]         eff_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam cap_t CAP_RESET = CAP_W'(16);

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  // Zero behaves as one, anything above the store size saturates.
  function automatic eff_t eff_cap(input cap_t c);
    eff_t w;
    w = EFF_W'(c);
    if (w == '0) begin
      w = EFF_W'(1);
    end else if (w > EFF_W'(ENTRIES)) begin
      w = EFF_W'(ENTRIES);
    end
    return w;
  endfunction

endpackage

>>> rtl/lkvc_if.sv
interface lkvc_item_if;
  logic                valid;
  logic                ready;
  logic                action;
  lkvc_pkg::data_t     key;
  lkvc_pkg::data_t     value;

  modport source (output valid, output action, output key, output value, input ready);
  modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface lkvc_result_if;
  logic                valid;
  logic                ready;
  logic                hit;
  lkvc_pkg::data_t     read_value;
  logic                evicted;
  lkvc_pkg::data_t     evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

>>> rtl/lru_key_value_cache_unit.sv
// Fully associative key/value cache with least-recently-used replacement.
// req carries one word per access: action (get or put), key and value.
// rsp returns one word per access: hit, read_value, evicted, evicted_key.
// cfg_we/cfg_wdata write the capacity register; any write empties the cache
// and must only happen while no access is in flight.
// Keys and values sit in two synchronous memories, each with one write and
// one read port. An access scans the key memory one entry per cycle through
// a registered read port and stops at the first match; recency ranks and valid
// bits are flip-flops.
// An accepted word moves through ST_SCAN, where each entry is compared as its
// registered key returns, and ST_FIN, where the access commits and loads the
// result; the unit then returns to ST_IDLE and takes the next word, so a new
// access is not accepted until the previous one has committed.
// The result sits in an output register; if rsp stalls while a result is
// still held, the following access waits in its final cycle and commits
// once the register frees up. Reset sets capacity to 16 and empties the
// cache; memory contents are not cleared, only valid bits.
module lru_key_value_cache_unit (
  input  logic                     clk,
  input  logic                     rst,
  lkvc_item_if.sink                req,
  lkvc_result_if.source            rsp,
  input  logic                     cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata
);

  localparam int ENTRIES = lkvc_pkg::ENTRIES;
  localparam int IDX_W   = lkvc_pkg::IDX_W;
  localparam int CNT_W   = lkvc_pkg::CNT_W;
  localparam int EFF_W   = lkvc_pkg::EFF_W;

  lkvc_pkg::state_t state, state_next;
  lkvc_pkg::cap_t   capacity;
  logic [ENTRIES-1:0] valid;
  lkvc_pkg::idx_t   rank      [ENTRIES];
  lkvc_pkg::idx_t   rank_next [ENTRIES];
  logic [ENTRIES-1:0] valid_next;
  lkvc_pkg::cnt_t   used_count, used_count_next;

  lkvc_pkg::data_t  key_mem [ENTRIES];
  lkvc_pkg::data_t  val_mem [ENTRIES];
  lkvc_pkg::data_t  key_rd, val_rd;

  logic             req_action;
  lkvc_pkg::data_t  req_key, req_value;

  lkvc_pkg::cnt_t   scan_cnt;
  logic             probe_live;
  lkvc_pkg::idx_t   probe_idx;
  lkvc_pkg::idx_t   rd_addr;
  logic             issue;

  logic             found;
  lkvc_pkg::idx_t   found_idx;
  lkvc_pkg::data_t  hit_value;
  lkvc_pkg::data_t  lru_key;

  logic             rsp_valid, rsp_hit, rsp_evicted;
  lkvc_pkg::data_t  rsp_read_value, rsp_evicted_key;

  logic             probe_match, scan_last, commit;
  logic             lru_ok, free_ok, full, use_evict, ins_ok, do_insert, do_write;
  lkvc_pkg::idx_t   lru_idx, free_idx, ins_slot, wr_slot, rank_tgt, found_rank;
  lkvc_pkg::cnt_t   used_m1;
  lkvc_pkg::eff_t   eff;

  assign rsp.valid       = rsp_valid;
  assign rsp.hit         = rsp_hit;
  assign rsp.read_value  = rsp_read_value;
  assign rsp.evicted     = rsp_evicted;
  assign rsp.evicted_key = rsp_evicted_key;
  assign req.ready       = (state == lkvc_pkg::ST_IDLE);

  assign rd_addr     = scan_cnt[IDX_W-1:0];
  assign issue       = (state == lkvc_pkg::ST_SCAN) && (scan_cnt < CNT_W'(ENTRIES));
  assign probe_match = probe_live && valid[probe_idx] && (key_rd == req_key);
  assign scan_last   = probe_live && (probe_idx == IDX_W'(ENTRIES - 1));
  assign commit      = (state == lkvc_pkg::ST_FIN) && (!rsp_valid || rsp.ready);

  assign used_m1  = used_count - CNT_W'(1);
  assign rank_tgt = used_m1[IDX_W-1:0];
  assign eff      = lkvc_pkg::eff_cap(capacity);
  assign full     = (EFF_W'(used_count) >= eff);

  // Least recent entry and first empty slot; both stay fixed during a scan.
  always_comb begin
    lru_ok   = 1'b0;
    lru_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!lru_ok && valid[i] && (rank[i] == rank_tgt)) begin
        lru_ok  = 1'b1;
        lru_idx = IDX_W'(i);
      end
      if (!free_ok && !valid[i]) begin
        free_ok  = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign use_evict  = full && lru_ok;
  assign ins_slot   = use_evict ? lru_idx : free_idx;
  assign ins_ok     = use_evict || free_ok;
  assign do_insert  = !found && (req_action == lkvc_pkg::ACT_PUT) && ins_ok;
  assign do_write   = (found && (req_action == lkvc_pkg::ACT_PUT)) || do_insert;
  assign wr_slot    = found ? found_idx : ins_slot;
  assign found_rank = rank[found_idx];

  always_comb begin
    rank_next       = rank;
    valid_next      = valid;
    used_count_next = used_count;
    if (found) begin
      // promote: younger entries age by one
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid[i] && (rank[i] < found_rank)) begin
          rank_next[i] = rank[i] + IDX_W'(1);
        end
      end
      rank_next[found_idx] = '0;
    end else if (do_insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid[i] && (IDX_W'(i) != ins_slot)) begin
          rank_next[i] = rank[i] + IDX_W'(1);
        end
      end
      rank_next[ins_slot]  = '0;
      valid_next[ins_slot] = 1'b1;
      if (!use_evict) begin
        used_count_next = used_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkvc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lkvc_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = lkvc_pkg::ST_SCAN;
        end
      end
      lkvc_pkg::ST_SCAN: begin
        if (probe_match || scan_last) begin
          state_next = lkvc_pkg::ST_FIN;
        end
      end
      lkvc_pkg::ST_FIN: begin
        if (commit) begin
          state_next = lkvc_pkg::ST_IDLE;
        end
      end
      default: state_next = lkvc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= lkvc_pkg::CAP_RESET;
      valid      <= '0;
      used_count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
      scan_cnt   <= '0;
      probe_live <= 1'b0;
      found      <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        scan_cnt <= '0;
        found    <= 1'b0;
      end else if (issue) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end
      probe_live <= issue;
      if (probe_match) begin
        found <= 1'b1;
      end
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (commit) begin
        rsp_valid  <= 1'b1;
        rank       <= rank_next;
        valid      <= valid_next;
        used_count <= used_count_next;
      end
      // a capacity write empties the cache
      if (cfg_we) begin
        capacity   <= cfg_wdata;
        valid      <= '0;
        used_count <= '0;
        for (int i = 0; i < ENTRIES; i++) begin
          rank[i] <= '0;
        end
      end
    end
  end

  // Writes land only in the final cycle and the next scan starts later,
  // so no read issued by a scan overlaps a write to the same entry.
  always_ff @(posedge clk) begin
    if (commit && do_insert) begin
      key_mem[ins_slot] <= req_key;
    end
    key_rd <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (commit && do_write) begin
      val_mem[wr_slot] <= req_value;
    end
    val_rd <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_action <= req.action;
      req_key    <= req.key;
      req_value  <= req.value;
    end
    probe_idx <= rd_addr;
    if (probe_match) begin
      found_idx <= probe_idx;
      hit_value <= val_rd;
    end
    // pick up the eviction candidate's key as the scan passes it
    if (probe_live && (probe_idx == lru_idx)) begin
      lru_key <= key_rd;
    end
    if (commit) begin
      rsp_hit         <= found;
      rsp_read_value  <= (found && (req_action == lkvc_pkg::ACT_GET)) ? hit_value : '0;
      rsp_evicted     <= do_insert && use_evict;
      rsp_evicted_key <= (do_insert && use_evict) ? lru_key : '0;
    end
  end

  a_used_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(used_count))
    else $error("used_count disagrees with valid bits");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == lkvc_pkg::ST_SCAN))
    else $error("accepted word did not start a scan");

  a_stall_holds_fin: assert property (@(posedge clk) disable iff (rst)
    ((state == lkvc_pkg::ST_FIN) && rsp_valid && !rsp.ready) |=>
      (state == lkvc_pkg::ST_FIN))
    else $error("access committed over a stalled result");

  a_cfg_empties: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> ((used_count == '0) && (valid == '0)))
    else $error("capacity write did not empty the cache");

endmodule
